// File: sv/eff_pkg.sv
`default_nettype none

package eff_pkg;

  localparam int FracBitsDefault = 16;
  localparam int GammaW          = 18;
  localparam logic [GammaW-1:0] GammaReset = 18'd91750;

  // divider: one quotient bit per stage, plus an entry and an exit stage
  localparam int DivSteps = 32;
  localparam int DivLat   = DivSteps + 2;

  localparam logic [31:0] WordMax = 32'h7fff_ffff;
  localparam logic [31:0] WordMin = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] dvs;
    logic        dz;
    logic        nz;
    logic        npos;
    logic        ovf;
    logic        neg;
  } div_stage_t;

  // saturate a wide signed value to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r.val = WordMax;
      r.ovf = 1'b1;
    end else if (v < 64'shffff_ffff_8000_0000) begin
      r.val = WordMin;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/eff_div.sv
`default_nettype none

module eff_div import eff_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] num,
  input  wire logic signed [31:0] den,
  output logic signed [31:0]      quo,
  output logic                    flt
);

  div_stage_t  stg [0:DivSteps];
  div_stage_t  st0;
  logic [63:0] mag_n;
  logic [31:0] mag_d;
  logic [31:0] q_next;
  logic        f_next;

  // take magnitudes, flag zero divisor and quotients that cannot fit 32 bits
  always_comb begin
    mag_n    = num[63] ? 64'(-num) : num;
    mag_d    = den[31] ? 32'(-den) : den;
    st0.rem  = mag_n[63:32];
    st0.lo   = mag_n[31:0];
    st0.dvs  = mag_d;
    st0.dz   = (den == 32'sd0);
    st0.nz   = (num == 64'sd0);
    st0.npos = !num[63] && (num != 64'sd0);
    st0.ovf  = (mag_n[63:32] >= mag_d);
    st0.neg  = num[63] ^ den[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= st0;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    div_stage_t  nxt;

    always_comb begin
      trial = {stg[k].rem, stg[k].lo[31]};
      diff  = trial - {1'b0, stg[k].dvs};
      nxt   = stg[k];
      nxt.rem = diff[32] ? trial[31:0] : diff[31:0];
      nxt.lo  = {stg[k].lo[30:0], !diff[32]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1] <= nxt;
      end
    end
  end

  // apply sign, saturate, handle zero divisor
  always_comb begin
    f_next = 1'b0;
    if (stg[DivSteps].dz) begin
      f_next = 1'b1;
      if (stg[DivSteps].npos)    q_next = WordMax;
      else if (stg[DivSteps].nz) q_next = 32'd0;
      else                       q_next = WordMin;
    end else if (stg[DivSteps].ovf) begin
      f_next = 1'b1;
      q_next = stg[DivSteps].neg ? WordMin : WordMax;
    end else if (stg[DivSteps].neg) begin
      if (stg[DivSteps].lo > WordMin) begin
        f_next = 1'b1;
        q_next = WordMin;
      end else begin
        q_next = 32'd0 - stg[DivSteps].lo;
      end
    end else if (stg[DivSteps].lo[31]) begin
      f_next = 1'b1;
      q_next = WordMax;
    end else begin
      q_next = stg[DivSteps].lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= q_next;
      flt <= f_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/euler_face_flux.sv
`default_nettype none

// Central flux of the 2D Euler equations on one X or Y cell face, signed fixed
// point with FRAC_BITS fraction bits. The pipeline takes one face per cycle
// unless stalled and passes it through 11 arithmetic stages plus two 34-stage
// dividers, one quotient bit per stage, in series: the kinetic-energy quotient
// feeds pressure, which feeds the energy flux quotient. A stall on the result
// side freezes the whole pipeline; in_stall follows it. Gamma is written over
// the cfg port, which is always ready; write it only while no face is in flight.
// fault marks a zero density or any saturated intermediate.
module euler_face_flux import eff_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic signed [31:0] density_a,
  input  wire logic signed [31:0] density_b,
  input  wire logic signed [31:0] vel_x_a,
  input  wire logic signed [31:0] vel_x_b,
  input  wire logic signed [31:0] vel_y_a,
  input  wire logic signed [31:0] vel_y_b,
  input  wire logic signed [31:0] energy_a,
  input  wire logic signed [31:0] energy_b,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [GammaW-1:0]  cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      flux_mass,
  output logic signed [31:0]      flux_normal_mom,
  output logic signed [31:0]      flux_tangent_mom,
  output logic signed [31:0]      flux_energy,
  output logic                    fault
);

  localparam int GfW = ((FRAC_BITS + 1 > GammaW) ? FRAC_BITS + 1 : GammaW) + 1;
  localparam int NSt = 11 + 2 * DivLat;

  typedef struct packed {
    logic signed [31:0] mn;
    logic signed [31:0] rho;
    logic signed [31:0] en;
    logic               flt;
  } dl1_t;

  typedef struct packed {
    logic signed [31:0] fn;
    logic signed [31:0] qmt;
    logic signed [31:0] mn;
    logic               flt;
  } dl2_t;

  logic              adv;
  logic [NSt-1:0]    vld;
  logic [GammaW-1:0] gamma;
  logic signed [GfW-1:0] gfac;

  logic a_kind;
  logic signed [31:0] a_da, a_db, a_vxa, a_vxb, a_vya, a_vyb, a_ea, a_eb;
  logic b_kind;
  logic signed [63:0] b_pxa, b_pxb, b_pya, b_pyb;
  logic signed [31:0] b_rho, b_en;
  logic signed [31:0] c_mn, c_mt, c_rho, c_en;
  logic c_flt;
  logic signed [63:0] d_mm, d_tt, d_nt;
  logic signed [31:0] d_mn, d_rho, d_en;
  logic d_flt;
  logic signed [63:0] e_sqh, e_mm, e_nt;
  logic signed [31:0] e_mn, e_rho, e_en;
  logic e_flt;
  logic signed [31:0] kin, qmm, qmt;
  logic f_kin, f_mm, f_mt;
  dl1_t dl1 [0:DivLat-1];
  logic signed [31:0] g_inner, g_qmm, g_qmt, g_mn, g_rho, g_en;
  logic g_flt;
  logic signed [GfW+31:0] h_pmul;
  logic signed [31:0] h_qmm, h_qmt, h_mn, h_rho, h_en;
  logic h_flt;
  logic signed [31:0] i_p, i_qmm, i_qmt, i_mn, i_rho, i_en;
  logic i_flt;
  logic signed [31:0] j_fn, j_h, j_qmt, j_mn, j_rho;
  logic j_flt;
  logic signed [63:0] k_hm;
  logic signed [31:0] k_rho;
  dl2_t k_dl;
  dl2_t dl2 [0:DivLat-1];
  logic signed [31:0] qe;
  logic f_e;

  logic signed [32:0] rho_sum, en_sum;
  logic signed [63:0] sx, sy;
  sat_t mx, my, inner_s, p_s, fn_s, h_s;
  logic [63:0] sq_sum;

  // advance everything unless a result is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;
  assign out_valid = vld[NSt-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      gamma <= GammaReset;
    end else begin
      if (adv) vld <= {vld[NSt-2:0], in_valid};
      if (cfg_valid) gamma <= cfg_data;
    end
  end

  assign gfac = $signed({{(GfW-GammaW){1'b0}}, gamma}) - $signed(GfW'(1) << FRAC_BITS);

  // arithmetic for the combinational parts
  always_comb begin
    rho_sum = 33'(a_da) + 33'(a_db);
    en_sum  = 33'(a_ea) + 33'(a_eb);
    sx      = (b_pxa >>> FRAC_BITS) + (b_pxb >>> FRAC_BITS);
    sy      = (b_pya >>> FRAC_BITS) + (b_pyb >>> FRAC_BITS);
    mx      = sat32(sx >>> 1);
    my      = sat32(sy >>> 1);
    sq_sum  = d_mm + d_tt;
    inner_s = sat32(64'(dl1[DivLat-1].en) - 64'(kin));
    p_s     = sat32(64'(h_pmul) >>> FRAC_BITS);
    fn_s    = sat32(64'(i_qmm) + 64'(i_p));
    h_s     = sat32(64'(i_en) + 64'(i_p));
  end

  // front stages: capture, products, momenta, squares
  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind <= kind;
      a_da   <= density_a;
      a_db   <= density_b;
      a_vxa  <= vel_x_a;
      a_vxb  <= vel_x_b;
      a_vya  <= vel_y_a;
      a_vyb  <= vel_y_b;
      a_ea   <= energy_a;
      a_eb   <= energy_b;

      b_kind <= a_kind;
      b_pxa  <= a_da * a_vxa;
      b_pxb  <= a_db * a_vxb;
      b_pya  <= a_da * a_vya;
      b_pyb  <= a_db * a_vyb;
      b_rho  <= rho_sum[32:1];
      b_en   <= en_sum[32:1];

      c_mn   <= b_kind ? my.val : mx.val;
      c_mt   <= b_kind ? mx.val : my.val;
      c_rho  <= b_rho;
      c_en   <= b_en;
      c_flt  <= mx.ovf | my.ovf;

      d_mm   <= c_mn * c_mn;
      d_tt   <= c_mt * c_mt;
      d_nt   <= c_mn * c_mt;
      d_mn   <= c_mn;
      d_rho  <= c_rho;
      d_en   <= c_en;
      d_flt  <= c_flt;

      e_sqh  <= {1'b0, sq_sum[63:1]};
      e_mm   <= d_mm;
      e_nt   <= d_nt;
      e_mn   <= d_mn;
      e_rho  <= d_rho;
      e_en   <= d_en;
      e_flt  <= d_flt;
    end
  end

  eff_div u_div_kin (.clk, .en(adv), .num(e_sqh), .den(e_rho), .quo(kin), .flt(f_kin));
  eff_div u_div_mm  (.clk, .en(adv), .num(e_mm),  .den(e_rho), .quo(qmm), .flt(f_mm));
  eff_div u_div_mt  (.clk, .en(adv), .num(e_nt),  .den(e_rho), .quo(qmt), .flt(f_mt));

  // carry side values alongside the first dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      dl1[0] <= '{mn: e_mn, rho: e_rho, en: e_en, flt: e_flt};
      for (int k = 1; k < DivLat; k++) dl1[k] <= dl1[k-1];
    end
  end

  // middle stages: pressure, normal flux, enthalpy, energy numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      g_inner <= inner_s.val;
      g_qmm   <= qmm;
      g_qmt   <= qmt;
      g_mn    <= dl1[DivLat-1].mn;
      g_rho   <= dl1[DivLat-1].rho;
      g_en    <= dl1[DivLat-1].en;
      g_flt   <= dl1[DivLat-1].flt | f_kin | f_mm | f_mt | inner_s.ovf;

      h_pmul  <= gfac * g_inner;
      h_qmm   <= g_qmm;
      h_qmt   <= g_qmt;
      h_mn    <= g_mn;
      h_rho   <= g_rho;
      h_en    <= g_en;
      h_flt   <= g_flt;

      i_p     <= p_s.val;
      i_qmm   <= h_qmm;
      i_qmt   <= h_qmt;
      i_mn    <= h_mn;
      i_rho   <= h_rho;
      i_en    <= h_en;
      i_flt   <= h_flt | p_s.ovf;

      j_fn    <= fn_s.val;
      j_h     <= h_s.val;
      j_qmt   <= i_qmt;
      j_mn    <= i_mn;
      j_rho   <= i_rho;
      j_flt   <= i_flt | fn_s.ovf | h_s.ovf;

      k_hm    <= j_h * j_mn;
      k_rho   <= j_rho;
      k_dl    <= '{fn: j_fn, qmt: j_qmt, mn: j_mn, flt: j_flt};
    end
  end

  eff_div u_div_e (.clk, .en(adv), .num(k_hm), .den(k_rho), .quo(qe), .flt(f_e));

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2[0] <= k_dl;
      for (int k = 1; k < DivLat; k++) dl2[k] <= dl2[k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      flux_mass        <= dl2[DivLat-1].mn;
      flux_normal_mom  <= dl2[DivLat-1].fn;
      flux_tangent_mom <= dl2[DivLat-1].qmt;
      flux_energy      <= qe;
      fault            <= dl2[DivLat-1].flt | f_e;
    end
  end

endmodule

`default_nettype wire
